### hw/rtl/tesp_pkg.sv
// Shared types and constants of the terminal escape sequence parser.
// Used by tesp_ctrl, tesp_dp and the top level; depends on nothing else.
`default_nettype none

package tesp_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_PARAMS_DEF = 16;
  localparam int unsigned PARAM_BITS_DEF = 16;

  // Fixed field widths of a result.
  localparam int unsigned CHAR_W  = 21;
  localparam int unsigned PIDX_W  = 4;
  localparam int unsigned PVAL_W  = 16;

  // Byte codes that the parser recognises.
  localparam logic [7:0] BYTE_BEL     = 8'h07;
  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_DEL     = 8'h7F;
  localparam logic [7:0] BYTE_FIN_LO  = 8'h40;
  localparam logic [7:0] BYTE_FIN_HI  = 8'h7E;
  localparam logic [7:0] BYTE_ZERO    = 8'h30;
  localparam logic [7:0] BYTE_NINE    = 8'h39;
  localparam logic [7:0] BYTE_SEMI    = 8'h3B;
  localparam logic [7:0] BYTE_QUEST   = 8'h3F;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] BYTE_RBRACK  = 8'h5D;
  localparam logic [7:0] BYTE_P       = 8'h50;
  localparam logic [7:0] BYTE_CARET   = 8'h5E;
  localparam logic [7:0] BYTE_USCORE  = 8'h5F;
  localparam logic [7:0] BYTE_LPAREN  = 8'h28;
  localparam logic [7:0] BYTE_RPAREN  = 8'h29;
  localparam logic [7:0] BYTE_STAR    = 8'h2A;
  localparam logic [7:0] BYTE_PLUS    = 8'h2B;
  localparam logic [7:0] BYTE_GT      = 8'h3E;
  localparam logic [7:0] BYTE_EXCL    = 8'h21;
  localparam logic [7:0] BYTE_DOLLAR  = 8'h24;
  localparam logic [7:0] BYTE_DQUOTE  = 8'h22;
  localparam logic [7:0] BYTE_SQUOTE  = 8'h27;

  // UTF-8 lead and continuation masks.
  localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF_CONT_VAL  = 8'h80;
  localparam logic [7:0] UTF_L2_MASK   = 8'hE0;
  localparam logic [7:0] UTF_L2_VAL    = 8'hC0;
  localparam logic [7:0] UTF_L3_MASK   = 8'hF0;
  localparam logic [7:0] UTF_L3_VAL    = 8'hE0;
  localparam logic [7:0] UTF_L4_MASK   = 8'hF8;
  localparam logic [7:0] UTF_L4_VAL    = 8'hF0;

  typedef enum logic [1:0] {
    KIND_CODEPOINT = 2'd0,
    KIND_CONTROL   = 2'd1,
    KIND_ESC_FINAL = 2'd2,
    KIND_CSI_PARAM = 2'd3
  } kind_t;

  // Classification of the current input byte, plus datapath status.
  typedef struct packed {
    logic is_esc;
    logic is_ctrl;      // below space, or DEL
    logic is_c0;        // below space
    logic is_digit;
    logic is_semi;
    logic is_quest;
    logic is_inter;     // intermediates that are accepted and ignored
    logic is_final;
    logic is_bel;
    logic is_lbrack;
    logic is_rbrack;
    logic is_dcs_open;
    logic is_cs_open;
    logic out_free;
    logic burst_last;
  } dp_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  clear_csi;
    logic  clear_utf8;
    logic  utf8_step;
    logic  emit_single;
    kind_t single_kind;
    logic  digit;
    logic  push;
    logic  set_priv;
    logic  start_burst;
    logic  emit_param;
    logic  idx_inc;
  } dp_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tesp_ctrl.sv
// Controller of the escape sequence parser: parse state and parameter burst sequencing.
// Depends on tesp_pkg; drives the command struct of tesp_dp.
`default_nettype none

module tesp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tesp_pkg::dp_status_t st,
  output tesp_pkg::dp_cmd_t        cmd
);
  import tesp_pkg::*;

  typedef enum logic [9:0] {
    S_GROUND  = 10'b00_0000_0001,
    S_ESC     = 10'b00_0000_0010,
    S_CSI     = 10'b00_0000_0100,
    S_OSC     = 10'b00_0000_1000,
    S_OSC_ESC = 10'b00_0001_0000,
    S_DCS     = 10'b00_0010_0000,
    S_DCS_ESC = 10'b00_0100_0000,
    S_CHARSET = 10'b00_1000_0000,
    S_READ    = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_burst;
  logic   accept;

  assign in_burst = (state_r == S_READ) || (state_r == S_EMIT);
  assign in_ready = !in_burst && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_GROUND: begin
        if (accept) begin
          if (st.is_esc) begin
            cmd.clear_csi  = 1'b1;
            cmd.clear_utf8 = 1'b1;
            state_nxt      = S_ESC;
          end else if (st.is_ctrl) begin
            cmd.emit_single = 1'b1;
            cmd.single_kind = KIND_CONTROL;
          end else begin
            cmd.utf8_step = 1'b1;
          end
        end
      end
      S_ESC: begin
        if (accept) begin
          if (st.is_lbrack) begin
            cmd.clear_csi = 1'b1;
            state_nxt     = S_CSI;
          end else if (st.is_rbrack) begin
            state_nxt = S_OSC;
          end else if (st.is_dcs_open) begin
            state_nxt = S_DCS;
          end else if (st.is_cs_open) begin
            state_nxt = S_CHARSET;
          end else begin
            cmd.emit_single = 1'b1;
            cmd.single_kind = KIND_ESC_FINAL;
            state_nxt       = S_GROUND;
          end
        end
      end
      S_CSI: begin
        if (accept) begin
          if (st.is_digit) begin
            cmd.digit = 1'b1;
          end else if (st.is_semi) begin
            cmd.push = 1'b1;
          end else if (st.is_quest) begin
            cmd.set_priv = 1'b1;
          end else if (st.is_inter) begin
            cmd.push = 1'b0;
          end else if (st.is_final) begin
            cmd.push        = 1'b1;
            cmd.start_burst = 1'b1;
            state_nxt       = S_READ;
          end else if (st.is_c0) begin
            cmd.emit_single = 1'b1;
            cmd.single_kind = KIND_CONTROL;
          end
        end
      end
      S_OSC: begin
        if (accept) begin
          if (st.is_bel) begin
            state_nxt = S_GROUND;
          end else if (st.is_esc) begin
            state_nxt = S_OSC_ESC;
          end
        end
      end
      S_DCS: begin
        if (accept && st.is_esc) begin
          state_nxt = S_DCS_ESC;
        end
      end
      S_OSC_ESC, S_DCS_ESC, S_CHARSET: begin
        if (accept) begin
          state_nxt = S_GROUND;
        end
      end
      // The parameter memory read is registered, so each entry passes through
      // this state before it can be presented.
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_param = 1'b1;
          if (st.burst_last) begin
            state_nxt = S_GROUND;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_GROUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_GROUND;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_EMIT)
    else $error("parameter read not followed by emit");

  a_burst_ends_ground: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_param && st.burst_last |=> state_r == S_GROUND)
    else $error("parameter burst did not return to ground");

  a_final_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_burst |=> state_r == S_READ)
    else $error("CSI final byte did not start a burst");

endmodule

`default_nettype wire

### hw/rtl/tesp_dp.sv
// Datapath of the escape sequence parser: byte classifier, UTF-8 assembly, CSI
// accumulator, parameter memory and result register. Depends on tesp_pkg.
`default_nettype none

module tesp_dp #(
  parameter int unsigned MAX_PARAMS = tesp_pkg::MAX_PARAMS_DEF,
  parameter int unsigned PARAM_BITS = tesp_pkg::PARAM_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [7:0]                   in_byte,
  input  wire tesp_pkg::dp_cmd_t            cmd,
  output tesp_pkg::dp_status_t              st,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_event_kind,
  output logic [tesp_pkg::CHAR_W-1:0]       out_char_value,
  output logic [tesp_pkg::PIDX_W-1:0]       out_param_index,
  output logic [tesp_pkg::PVAL_W-1:0]       out_param_value,
  output logic                              out_param_given,
  output logic                              out_private_mode,
  output logic                              out_last
);
  import tesp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_PARAMS);
  localparam int unsigned ACC_W = PARAM_BITS + 4;
  localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

  logic [7:0] b;
  logic       burst_last;
  logic       out_free;
  assign b = in_byte;

  // Byte classification.
  always_comb begin
    st.is_esc      = (b == BYTE_ESC);
    st.is_c0       = (b < BYTE_SPACE);
    st.is_ctrl     = (b < BYTE_SPACE) || (b == BYTE_DEL);
    st.is_digit    = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    st.is_semi     = (b == BYTE_SEMI);
    st.is_quest    = (b == BYTE_QUEST);
    st.is_inter    = (b == BYTE_GT) || (b == BYTE_EXCL) || (b == BYTE_DOLLAR) ||
                     (b == BYTE_DQUOTE) || (b == BYTE_SQUOTE) ||
                     (b == BYTE_SPACE) || (b == BYTE_STAR);
    st.is_final    = (b >= BYTE_FIN_LO) && (b <= BYTE_FIN_HI);
    st.is_bel      = (b == BYTE_BEL);
    st.is_lbrack   = (b == BYTE_LBRACK);
    st.is_rbrack   = (b == BYTE_RBRACK);
    st.is_dcs_open = (b == BYTE_P) || (b == BYTE_CARET) || (b == BYTE_USCORE);
    st.is_cs_open  = (b == BYTE_LPAREN) || (b == BYTE_RPAREN) ||
                     (b == BYTE_STAR) || (b == BYTE_PLUS);
    st.out_free    = out_free;
    st.burst_last  = burst_last;
  end

  // ---------------------------------------------------------------- UTF-8
  logic [CHAR_W-1:0] pc_r, pc_nxt, pc_cat, u_char;
  logic [1:0]        need_r, need_nxt;
  logic              u_emit;

  assign pc_cat = {pc_r[CHAR_W-7:0], b[5:0]};

  always_comb begin
    pc_nxt   = pc_r;
    need_nxt = need_r;
    u_emit   = 1'b0;
    u_char   = '0;
    if (cmd.clear_utf8) begin
      pc_nxt   = '0;
      need_nxt = '0;
    end else if (cmd.utf8_step) begin
      if ((need_r != 2'd0) && ((b & UTF_CONT_MASK) == UTF_CONT_VAL)) begin
        need_nxt = need_r - 2'd1;
        if (need_r == 2'd1) begin
          u_emit = 1'b1;
          u_char = pc_cat;
          pc_nxt = '0;
        end else begin
          pc_nxt = pc_cat;
        end
      end else begin
        // Any partial character is dropped and the byte is taken afresh.
        pc_nxt   = '0;
        need_nxt = '0;
        if (b < UTF_CONT_VAL) begin
          u_emit = 1'b1;
          u_char = CHAR_W'(b);
        end else if ((b & UTF_L2_MASK) == UTF_L2_VAL) begin
          pc_nxt   = CHAR_W'(b[4:0]);
          need_nxt = 2'd1;
        end else if ((b & UTF_L3_MASK) == UTF_L3_VAL) begin
          pc_nxt   = CHAR_W'(b[3:0]);
          need_nxt = 2'd2;
        end else if ((b & UTF_L4_MASK) == UTF_L4_VAL) begin
          pc_nxt   = CHAR_W'(b[2:0]);
          need_nxt = 2'd3;
        end
      end
    end
  end

  // ---------------------------------------------------------------- CSI
  logic [PARAM_BITS-1:0] acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  priv_r, priv_nxt;
  logic [ACC_W-1:0]      acc_ext, acc_mul;
  logic                  store_wr;
  logic [PARAM_BITS:0]   store_wdata;

  assign acc_ext     = ACC_W'(acc_r);
  assign acc_mul     = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(b[3:0]);
  assign store_wr    = cmd.push && (count_r < CNT_W'(MAX_PARAMS));
  assign store_wdata = {seen_r, (seen_r ? acc_r : '0)};

  always_comb begin
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    count_nxt = count_r;
    priv_nxt  = priv_r;
    if (cmd.clear_csi) begin
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      count_nxt = '0;
      priv_nxt  = 1'b0;
    end else if (cmd.digit) begin
      acc_nxt  = (acc_mul[ACC_W-1:PARAM_BITS] != 4'd0) ? PARAM_MAX
                                                      : acc_mul[PARAM_BITS-1:0];
      seen_nxt = 1'b1;
    end else if (cmd.push) begin
      acc_nxt  = '0;
      seen_nxt = 1'b0;
      if (store_wr) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (cmd.set_priv) begin
      priv_nxt = 1'b1;
    end
  end

  // Parameter memory: one write port at the fill count, one registered read.
  logic [PARAM_BITS:0] store_mem [MAX_PARAMS];
  logic [PARAM_BITS:0] rd_r;
  logic [IDX_W-1:0]    idx_r;
  logic [7:0]          final_r;

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_mem[count_r[IDX_W-1:0]] <= store_wdata;
    end
    rd_r <= store_mem[idx_r];
  end

  assign burst_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      need_r  <= '0;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      count_r <= '0;
      priv_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      pc_r    <= pc_nxt;
      need_r  <= need_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      count_r <= count_nxt;
      priv_r  <= priv_nxt;
      if (cmd.start_burst) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_burst) begin
      final_r <= b;
    end
  end

  // ---------------------------------------------------------------- result
  logic        out_valid_r;
  logic        load;
  logic [31:0] idx_ext, val_ext;

  assign load        = cmd.emit_single || u_emit || cmd.emit_param;
  assign out_free    = !out_valid_r || out_ready;
  assign idx_ext     = 32'(idx_r);
  assign val_ext     = 32'(rd_r[PARAM_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.emit_param) begin
        out_event_kind   <= KIND_CSI_PARAM;
        out_char_value   <= CHAR_W'(final_r);
        out_param_index  <= idx_ext[PIDX_W-1:0];
        out_param_value  <= val_ext[PVAL_W-1:0];
        out_param_given  <= rd_r[PARAM_BITS];
        out_private_mode <= priv_r;
        out_last         <= burst_last;
      end else begin
        out_param_index  <= '0;
        out_param_value  <= '0;
        out_param_given  <= 1'b0;
        out_private_mode <= 1'b0;
        out_last         <= 1'b1;
        if (cmd.emit_single) begin
          out_event_kind <= cmd.single_kind;
          out_char_value <= CHAR_W'(b);
        end else begin
          out_event_kind <= KIND_CODEPOINT;
          out_char_value <= u_char;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PARAMS))
    else $error("parameter count beyond store depth");

  a_utf8_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    need_r == 2'd0 |-> pc_r == '0)
    else $error("partial codepoint left with no continuation pending");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_param |-> (CNT_W'(idx_r) < count_r))
    else $error("parameter emitted beyond fill count");

endmodule

`default_nettype wire

### hw/rtl/terminal_escape_sequence_parser_top.sv
// Top level of the terminal escape sequence parser.
// Instantiates tesp_ctrl and tesp_dp; depends on tesp_pkg.
`default_nettype none

// The block takes one host byte per transaction and, most of the time, accepts
// a byte every clock cycle; a byte is taken whenever no parameter burst is in
// progress and the result register is empty or its result is being taken in
// the same cycle. Printable codepoints, control bytes and escape final bytes
// give at most one result per byte. A CSI final byte starts a burst of one
// result per stored parameter, N being the number of parameters (1 to
// MAX_PARAMS); each entry is read from the parameter memory through its
// registered read port before it reaches the result register, and no byte is
// accepted while the burst lasts. The last result of every byte carries
// out_last. OSC, DCS and charset sequences are absorbed without results.
module terminal_escape_sequence_parser_top #(
  parameter int unsigned MAX_PARAMS = tesp_pkg::MAX_PARAMS_DEF,
  parameter int unsigned PARAM_BITS = tesp_pkg::PARAM_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_event_kind,
  output logic [tesp_pkg::CHAR_W-1:0]       out_char_value,
  output logic [tesp_pkg::PIDX_W-1:0]       out_param_index,
  output logic [tesp_pkg::PVAL_W-1:0]       out_param_value,
  output logic                              out_param_given,
  output logic                              out_private_mode,
  output logic                              out_last
);
  import tesp_pkg::*;

  dp_status_t st;
  dp_cmd_t    cmd;

  tesp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tesp_dp #(
    .MAX_PARAMS (MAX_PARAMS),
    .PARAM_BITS (PARAM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_char_value   (out_char_value),
    .out_param_index  (out_param_index),
    .out_param_value  (out_param_value),
    .out_param_given  (out_param_given),
    .out_private_mode (out_private_mode),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### test/terminal_escape_sequence_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of terminal_escape_sequence_parser_top: directed and random byte
// streams, with every result checked against a behavioural parser held in the testbench.
// Depends on tesp_pkg and the RTL of the parser.
module terminal_escape_sequence_parser_top_tb;
  import tesp_pkg::*;

  localparam int unsigned DEPTH       = MAX_PARAMS_DEF;
  localparam longint unsigned VAL_MAX = (64'd1 << PARAM_BITS_DEF) - 1;
  localparam int unsigned RANDOM_BYTES = 310;
  localparam int unsigned DRAIN_CYCLES = 4 * DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef enum logic [2:0] {
    PS_GROUND, PS_ESC, PS_CSI, PS_OSC, PS_OSC_ESC, PS_DCS, PS_DCS_ESC, PS_CHARSET
  } parse_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  ch;
    logic [PIDX_W-1:0]  idx;
    logic [PVAL_W-1:0]  val;
    logic               given;
    logic               priv;
    logic               is_last;
  } term_event_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [CHAR_W-1:0] out_char_value;
  logic [PIDX_W-1:0] out_param_index;
  logic [PVAL_W-1:0] out_param_value;
  logic out_param_given;
  logic out_private_mode;
  logic out_last;

  terminal_escape_sequence_parser_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_char_value   (out_char_value),
    .out_param_index  (out_param_index),
    .out_param_value  (out_param_value),
    .out_param_given  (out_param_given),
    .out_private_mode (out_private_mode),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser state as the block should hold it.
  parse_state_t    pstate = PS_GROUND;
  longint unsigned acc_value = 0;
  bit              acc_has_digits = 1'b0;
  longint unsigned param_vals[DEPTH];
  bit              param_set[DEPTH];
  int unsigned     n_params = 0;
  bit              private_seen = 1'b0;
  logic [CHAR_W-1:0] utf8_partial = '0;
  int unsigned     utf8_pending = 0;

  term_event_t expected_events[$];
  logic [7:0]  seq_bytes[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  function automatic void add_byte(logic [7:0] v);
    seq_bytes.insert(seq_bytes.size(), v);
  endfunction

  function automatic void queue_event(kind_t k, logic [CHAR_W-1:0] ch, int unsigned idx,
                                      longint unsigned val, bit given, bit priv, bit is_last);
    term_event_t ev;
    ev.kind    = k;
    ev.ch      = ch;
    ev.idx     = idx[PIDX_W-1:0];
    ev.val     = val[PVAL_W-1:0];
    ev.given   = given;
    ev.priv    = priv;
    ev.is_last = is_last;
    expected_events.insert(expected_events.size(), ev);
  endfunction

  function automatic void clear_csi_state();
    acc_value      = 0;
    acc_has_digits = 1'b0;
    n_params       = 0;
    private_seen   = 1'b0;
  endfunction

  // Parameters past the store depth are dropped, but the accumulator is still cleared.
  function automatic void close_param();
    if (n_params < DEPTH) begin
      param_vals[n_params] = acc_has_digits ? acc_value : 0;
      param_set[n_params]  = acc_has_digits;
      n_params++;
    end
    acc_value      = 0;
    acc_has_digits = 1'b0;
  endfunction

  function automatic void decode_ground(logic [7:0] c);
    if (c == BYTE_ESC) begin
      pstate = PS_ESC;
      clear_csi_state();
      utf8_partial = '0;
      utf8_pending = 0;
      return;
    end
    // Controls leave a half-built character where it is.
    if (c < BYTE_SPACE || c == BYTE_DEL) begin
      queue_event(KIND_CONTROL, CHAR_W'(c), 0, 0, 1'b0, 1'b0, 1'b1);
      return;
    end
    if (utf8_pending != 0) begin
      if ((c & UTF_CONT_MASK) == UTF_CONT_VAL) begin
        utf8_partial = {utf8_partial[CHAR_W-7:0], c[5:0]};
        utf8_pending--;
        if (utf8_pending == 0) begin
          queue_event(KIND_CODEPOINT, utf8_partial, 0, 0, 1'b0, 1'b0, 1'b1);
          utf8_partial = '0;
        end
        return;
      end
      utf8_partial = '0;
      utf8_pending = 0;
    end
    if (!c[7]) begin
      queue_event(KIND_CODEPOINT, CHAR_W'(c), 0, 0, 1'b0, 1'b0, 1'b1);
    end else if ((c & UTF_L2_MASK) == UTF_L2_VAL) begin
      utf8_partial = CHAR_W'(c[4:0]);
      utf8_pending = 1;
    end else if ((c & UTF_L3_MASK) == UTF_L3_VAL) begin
      utf8_partial = CHAR_W'(c[3:0]);
      utf8_pending = 2;
    end else if ((c & UTF_L4_MASK) == UTF_L4_VAL) begin
      utf8_partial = CHAR_W'(c[2:0]);
      utf8_pending = 3;
    end
  endfunction

  function automatic void decode_csi(logic [7:0] c);
    longint unsigned next;
    if (c >= BYTE_ZERO && c <= BYTE_NINE) begin
      next           = acc_value * 10 + (c - BYTE_ZERO);
      acc_value      = (next > VAL_MAX) ? VAL_MAX : next;
      acc_has_digits = 1'b1;
    end else if (c == BYTE_SEMI) begin
      close_param();
    end else if (c == BYTE_QUEST) begin
      private_seen = 1'b1;
    end else if (c inside {BYTE_GT, BYTE_EXCL, BYTE_DOLLAR, BYTE_DQUOTE, BYTE_SQUOTE,
                           BYTE_SPACE, BYTE_STAR}) begin
      // Intermediates other than the private marker change nothing.
    end else if (c >= BYTE_FIN_LO && c <= BYTE_FIN_HI) begin
      close_param();
      for (int unsigned i = 0; i < n_params; i++) begin
        queue_event(KIND_CSI_PARAM, CHAR_W'(c), i, param_vals[i], param_set[i], private_seen,
                    i + 1 == n_params);
      end
      pstate = PS_GROUND;
    end else if (c < BYTE_SPACE) begin
      queue_event(KIND_CONTROL, CHAR_W'(c), 0, 0, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    case (pstate)
      PS_GROUND: decode_ground(c);
      PS_ESC: begin
        case (c)
          BYTE_LBRACK: begin
            pstate = PS_CSI;
            clear_csi_state();
          end
          BYTE_RBRACK: pstate = PS_OSC;
          BYTE_P, BYTE_CARET, BYTE_USCORE: pstate = PS_DCS;
          BYTE_LPAREN, BYTE_RPAREN, BYTE_STAR, BYTE_PLUS: pstate = PS_CHARSET;
          default: begin
            pstate = PS_GROUND;
            queue_event(KIND_ESC_FINAL, CHAR_W'(c), 0, 0, 1'b0, 1'b0, 1'b1);
          end
        endcase
      end
      PS_CSI: decode_csi(c);
      PS_OSC: begin
        if (c == BYTE_BEL) pstate = PS_GROUND;
        else if (c == BYTE_ESC) pstate = PS_OSC_ESC;
      end
      PS_DCS: begin
        if (c == BYTE_ESC) pstate = PS_DCS_ESC;
      end
      default: pstate = PS_GROUND;
    endcase
  endfunction

  // Sends one byte; the sender works in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq();
    foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
    seq_bytes.delete();
  endtask

  // Receiver: the stall pattern is picked at random from four modes, including fully ready stretches.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= (cycle_count[1:0] == 2'b11);
      default: out_ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_events
    term_event_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: event with none expected, expected nothing, actual kind %0d char %0h",
                 $time, out_event_kind, out_char_value);
        mismatches++;
      end else begin
        want = expected_events[0];
        expected_events.delete(0);
        check_field("event_kind", want.kind, out_event_kind);
        check_field("char_value", want.ch, out_char_value);
        check_field("param_index", want.idx, out_param_index);
        check_field("param_value", want.val, out_param_value);
        check_field("param_given", want.given, out_param_given);
        check_field("private_mode", want.priv, out_private_mode);
        check_field("last", want.is_last, out_last);
      end
    end
  end

  task automatic test_ground_decoding();
    // Printable extremes, control extremes, a control inside a two-byte character,
    // a four-byte character, a broken character, a stray continuation and an invalid lead.
    seq_bytes = '{8'h20, 8'h7E, 8'h00, BYTE_DEL, 8'hC3, 8'h0A, 8'hA9,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41, 8'h80, 8'hFF};
    send_seq();
  endtask

  task automatic test_escape_finals();
    // ESC drops the pending lead byte; ESC after ESC is reported as a final byte.
    seq_bytes = '{8'hC2, BYTE_ESC, BYTE_ESC, BYTE_ESC, 8'h63};
    send_seq();
  endtask

  task automatic test_csi_parameters();
    // Private marker, ignored intermediate, saturating value, empty parameter,
    // ESC reported as a control inside the CSI and an ignored colon.
    seq_bytes = '{BYTE_ESC, BYTE_LBRACK, BYTE_QUEST, BYTE_DOLLAR, 8'h39, 8'h39, 8'h39, 8'h39,
                  8'h39, BYTE_SEMI, BYTE_SEMI, BYTE_ESC, 8'h3A, 8'h68};
    send_seq();
  endtask

  task automatic test_swallowed_sequences();
    seq_bytes = '{BYTE_ESC, BYTE_RBRACK, 8'h41, BYTE_BEL,
                  BYTE_ESC, BYTE_P, BYTE_ESC, 8'h5C,
                  BYTE_ESC, BYTE_LPAREN, 8'h42};
    send_seq();
  endtask

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic void build_csi();
    logic [7:0] inters[7] = '{BYTE_GT, BYTE_EXCL, BYTE_DOLLAR, BYTE_DQUOTE, BYTE_SQUOTE,
                              BYTE_SPACE, BYTE_STAR};
    logic [7:0] ignored[4] = '{8'h3A, 8'h3C, 8'h3D, BYTE_DEL};
    int unsigned np;
    int unsigned nd;
    add_byte(BYTE_ESC);
    add_byte(BYTE_LBRACK);
    if ($urandom_range(0, 2) == 0) add_byte(BYTE_QUEST);
    if ($urandom_range(0, 4) == 0) add_byte(inters[$urandom_range(0, 6)]);
    np = ($urandom_range(0, 9) < 3) ? $urandom_range(14, 20) : $urandom_range(0, 4);
    for (int unsigned p = 0; p < np; p++) begin
      nd = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
      repeat (nd) add_byte(BYTE_ZERO + 8'($urandom_range(0, 9)));
      case ($urandom_range(0, 19))
        0: add_byte(8'($urandom_range(0, 31)));
        1: add_byte(ignored[$urandom_range(0, 3)]);
        2: add_byte(8'($urandom_range(128, 255)));
        default: ;
      endcase
      if (p + 1 < np) add_byte(BYTE_SEMI);
    end
    add_byte(8'($urandom_range(BYTE_FIN_LO, BYTE_FIN_HI)));
  endfunction

  function automatic void build_utf8(int unsigned len);
    case (len)
      2: add_byte({3'b110, 5'($urandom_range(0, 31))});
      3: add_byte({4'b1110, 4'($urandom_range(0, 15))});
      default: add_byte({5'b11110, 3'($urandom_range(0, 7))});
    endcase
  endfunction

  function automatic void build_random_sequence();
    logic [7:0] dcs_open[3] = '{BYTE_P, BYTE_CARET, BYTE_USCORE};
    logic [7:0] cs_open[4]  = '{BYTE_LPAREN, BYTE_RPAREN, BYTE_STAR, BYTE_PLUS};
    int unsigned pick;
    int unsigned len;
    logic [7:0] ctl;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 28) begin
      len = $urandom_range(2, 4);
      build_utf8(len);
      repeat (len - 1) add_byte(rand_cont());
    end else if (pick < 35) begin
      ctl = 8'($urandom_range(0, 31));
      add_byte(ctl == BYTE_ESC ? BYTE_DEL : ctl);
    end else if (pick < 63) begin
      build_csi();
    end else if (pick < 70) begin
      add_byte(BYTE_ESC);
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      add_byte(BYTE_ESC);
      case ($urandom_range(0, 2))
        0: begin
          add_byte(BYTE_RBRACK);
          repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
          if ($urandom_range(0, 1) == 0) begin
            add_byte(BYTE_BEL);
          end else begin
            add_byte(BYTE_ESC);
            add_byte(8'($urandom_range(0, 255)));
          end
        end
        1: begin
          add_byte(dcs_open[$urandom_range(0, 2)]);
          repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
          add_byte(BYTE_ESC);
          add_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          add_byte(cs_open[$urandom_range(0, 3)]);
          add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end else if (pick < 88) begin
      // Truncated character followed by a fresh byte, a stray continuation, or a bad lead.
      case ($urandom_range(0, 2))
        0: begin
          len = $urandom_range(2, 4);
          build_utf8(len);
          repeat ($urandom_range(0, len - 2)) add_byte(rand_cont());
          add_byte(8'($urandom_range(8'h20, 8'hF7)));
        end
        1: add_byte(rand_cont());
        default: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_random_stream();
    int unsigned stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      build_random_sequence();
      send_seq();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_ground_decoding();
    test_escape_finals();
    test_csi_parameters();
    test_swallowed_sequences();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
